// ===== design/mtpos_pkg.sv =====
// ----------------------------------------------------------------------------
// mtpos_pkg: shared types and constants of the pump one-shot
// payload structs, configuration register indexes, reset values and defaults
// ----------------------------------------------------------------------------
package mtpos_pkg;

  // default storage widths
  localparam int TIMER_WIDTH_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 32;

  // configuration register indexes
  localparam logic [1:0] REG_RUN_TICKS   = 2'd0;
  localparam logic [1:0] REG_HOLD_TICKS  = 2'd1;
  localparam logic [1:0] REG_START_COUNT = 2'd2;
  localparam logic [1:0] REG_START_SLOT  = 2'd3;

  // reset values of the configuration registers
  localparam logic [15:0] RESET_TICKS       = 16'd5000;
  localparam logic [31:0] RESET_START_COUNT = 32'd0;
  localparam logic [7:0]  RESET_START_SLOT  = 8'd0;

  // slot divisor, 2^16 - 1
  localparam logic [16:0] SLOT_DIVISOR = 17'h0ffff;

  typedef struct packed {
    logic sensor_level;
    logic test_mode;
  } item_t;

  typedef struct packed {
    logic        relay_on;
    logic [31:0] event_total;
    logic [7:0]  slot_now;
    logic        store_slot;
    logic        store_total;
  } result_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_wr_t;

endpackage

// ===== design/mtpos_slot.sv =====
// ----------------------------------------------------------------------------
// mtpos_slot: storage slot index from the event count
// divides a 32-bit count by 2^16 - 1 with two narrow adds and two compares
// ----------------------------------------------------------------------------
module mtpos_slot (
  input  logic [31:0] count,
  output logic [16:0] quotient
);

  logic [16:0] digit_sum;
  logic [16:0] extra;

  // n = hi*65536 + lo = hi*65535 + (hi + lo), and hi + lo < 2*65535 + 1
  always_comb begin
    digit_sum = {1'b0, count[31:16]} + {1'b0, count[15:0]};
    if (digit_sum >= {mtpos_pkg::SLOT_DIVISOR[15:0], 1'b0}) begin
      extra = 17'd2;
    end else if (digit_sum >= mtpos_pkg::SLOT_DIVISOR) begin
      extra = 17'd1;
    end else begin
      extra = 17'd0;
    end
    quotient = {1'b0, count[31:16]} + extra;
  end

endmodule

// ===== design/mtpos_core.sv =====
// ----------------------------------------------------------------------------
// mtpos_core: timer, edge tracker, event counter and configuration store
// works one tick a cycle while fire is high and presents the result of the tick being worked
// ----------------------------------------------------------------------------
module mtpos_core #(
  parameter int TIMER_WIDTH = mtpos_pkg::TIMER_WIDTH_DEF,
  parameter int COUNT_WIDTH = mtpos_pkg::COUNT_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  mtpos_pkg::item_t    item,
  input  mtpos_pkg::cfg_wr_t  cfg_wr,
  output mtpos_pkg::result_t  result
);

  localparam logic [1:0] PHASE_ARMED = 2'd0;
  localparam logic [1:0] PHASE_RUN   = 2'd1;
  localparam logic [1:0] PHASE_HOLD  = 2'd2;

  // configuration
  logic [15:0] run_ticks;
  logic [15:0] hold_ticks;

  // state
  logic [1:0]             phase;
  logic [TIMER_WIDTH-1:0] ticks_left;
  logic                   level_before;
  logic                   relay_state;
  logic [COUNT_WIDTH-1:0] event_count;
  logic [7:0]             slot_index;

  logic [1:0]             phase_next;
  logic [TIMER_WIDTH-1:0] ticks_left_next;
  logic                   level_before_next;
  logic                   relay_state_next;
  logic [COUNT_WIDTH-1:0] event_count_next;
  logic [7:0]             slot_index_next;

  logic                   expire;
  logic                   trigger;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [16:0]            quotient;
  logic                   slot_differs;

  assign count_inc = event_count + COUNT_WIDTH'(1);

  mtpos_slot u_slot (
    .count    (32'(count_inc)),
    .quotient (quotient)
  );

  // full quotient against the 8-bit index: never equal above 255
  assign slot_differs = (quotient[16:8] != 9'd0) || (quotient[7:0] != slot_index);

  always_comb begin
    expire            = (ticks_left[TIMER_WIDTH-1:1] == '0);
    phase_next        = phase;
    ticks_left_next   = ticks_left;
    relay_state_next  = relay_state;
    level_before_next = level_before;
    event_count_next  = event_count;
    slot_index_next   = slot_index;
    trigger           = 1'b0;

    // timer expiries first
    case (phase)
      PHASE_RUN: begin
        if (expire) begin
          relay_state_next = 1'b0;
          phase_next       = PHASE_HOLD;
          ticks_left_next  = TIMER_WIDTH'(hold_ticks);
        end else begin
          ticks_left_next = ticks_left - TIMER_WIDTH'(1);
        end
      end
      PHASE_HOLD: begin
        if (expire) begin
          phase_next      = PHASE_ARMED;
          ticks_left_next = '0;
        end else begin
          ticks_left_next = ticks_left - TIMER_WIDTH'(1);
        end
      end
      default: begin
        phase_next = PHASE_ARMED;
      end
    endcase

    if (item.test_mode) begin
      relay_state_next = item.sensor_level;
    end else begin
      level_before_next = item.sensor_level;
      trigger = item.sensor_level && !level_before && (phase_next == PHASE_ARMED);
      if (trigger) begin
        relay_state_next = 1'b1;
        phase_next       = PHASE_RUN;
        ticks_left_next  = TIMER_WIDTH'(run_ticks);
        event_count_next = count_inc;
        if (slot_differs) begin
          slot_index_next = quotient[7:0];
        end
      end
    end

    result.relay_on    = relay_state_next;
    result.event_total = 32'(event_count_next);
    result.slot_now    = slot_index_next;
    result.store_slot  = trigger && slot_differs;
    result.store_total = trigger;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_ticks    <= mtpos_pkg::RESET_TICKS;
      hold_ticks   <= mtpos_pkg::RESET_TICKS;
      phase        <= PHASE_ARMED;
      ticks_left   <= '0;
      level_before <= 1'b1;
      relay_state  <= 1'b0;
      event_count  <= COUNT_WIDTH'(mtpos_pkg::RESET_START_COUNT);
      slot_index   <= mtpos_pkg::RESET_START_SLOT;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.index)
        mtpos_pkg::REG_RUN_TICKS:   run_ticks   <= cfg_wr.data[15:0];
        mtpos_pkg::REG_HOLD_TICKS:  hold_ticks  <= cfg_wr.data[15:0];
        mtpos_pkg::REG_START_COUNT: event_count <= COUNT_WIDTH'(cfg_wr.data);
        mtpos_pkg::REG_START_SLOT:  slot_index  <= cfg_wr.data[7:0];
        default: begin
        end
      endcase
    end else if (fire) begin
      phase        <= phase_next;
      ticks_left   <= ticks_left_next;
      level_before <= level_before_next;
      relay_state  <= relay_state_next;
      event_count  <= event_count_next;
      slot_index   <= slot_index_next;
    end
  end

endmodule

// ===== design/motion_triggered_pump_one_shot.sv =====
// ----------------------------------------------------------------------------
// motion_triggered_pump_one_shot: motion-triggered pump relay one-shot
// Takes one millisecond tick per transaction (sensor level and test switch)
// and returns one result per tick: relay drive, event total, storage slot
// index and the two storage-write flags. A tick is held in the input
// register and then moves into the result register, which presents its
// result; one tick per cycle is taken for as long as the result side keeps
// taking results, the rate being set by the single state update per cycle
// in the core. Configuration writes are always ready and must only be
// issued while no tick is in flight. A write to the start count or start
// slot register also loads the live count or slot index.
// ----------------------------------------------------------------------------
module motion_triggered_pump_one_shot #(
  parameter int TIMER_WIDTH = mtpos_pkg::TIMER_WIDTH_DEF,
  parameter int COUNT_WIDTH = mtpos_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // tick transactions
  input  logic               item_valid,
  output logic               item_stall,
  input  mtpos_pkg::item_t   item,
  // result transactions
  output logic               result_valid,
  input  logic               result_stall,
  output mtpos_pkg::result_t result,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  // input register
  logic               in_full;
  mtpos_pkg::item_t   in_item;

  // handshake between the two stages
  logic               advance;
  logic               fire;
  mtpos_pkg::result_t core_result;
  mtpos_pkg::cfg_wr_t cfg_wr;

  // result register can take a new result when empty or being emptied
  assign advance    = !result_valid || !result_stall;
  assign fire       = in_full && advance;
  // input register holds only while its tick cannot move on
  assign item_stall = in_full && !advance;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!item_stall) begin
      in_full <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_item <= item;
    end
  end

  // timers, edge tracker, counter and slot logic
  mtpos_core #(
    .TIMER_WIDTH (TIMER_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_item),
    .cfg_wr (cfg_wr),
    .result (core_result)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= core_result;
    end
  end

endmodule

// ===== verif/mtpos_checker.sv =====
// ----------------------------------------------------------------------------
// mtpos_checker: scoreboard of the pump one-shot
// follows configuration writes and accepted ticks, works out the result of
// each tick and compares it with the result transactions as they are taken
// ----------------------------------------------------------------------------
module mtpos_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_stall,
  input  mtpos_pkg::item_t   item,
  input  logic               result_valid,
  input  logic               result_stall,
  input  mtpos_pkg::result_t result,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);

  localparam logic [1:0] PH_ARMED = 2'd0;
  localparam logic [1:0] PH_RUN   = 2'd1;
  localparam logic [1:0] PH_HOLD  = 2'd2;

  logic [15:0] run_len;
  logic [15:0] hold_len;
  logic [1:0]  ph;
  logic [15:0] left;
  logic        lvl_prev;
  logic        relay;
  logic [31:0] count;
  logic [7:0]  slot;

  mtpos_pkg::result_t due_results [$];
  int                 errs = 0;

  // one millisecond tick of the pump controller
  task automatic advance_pump(input mtpos_pkg::item_t t, output mtpos_pkg::result_t r);
    logic [31:0] quot;
    logic        rose;
    r = '0;
    case (ph)
      PH_RUN: begin
        if (left <= 16'd1) begin
          relay = 1'b0;
          ph    = PH_HOLD;
          left  = hold_len;
        end else begin
          left = left - 16'd1;
        end
      end
      PH_HOLD: begin
        if (left <= 16'd1) begin
          left = '0;
          ph   = PH_ARMED;
        end else begin
          left = left - 16'd1;
        end
      end
      default: ph = PH_ARMED;
    endcase
    if (t.test_mode) begin
      relay = t.sensor_level;
    end else begin
      rose = 1'b0;
      if (t.sensor_level) begin
        if (!lvl_prev) begin
          lvl_prev = 1'b1;
          rose     = 1'b1;
        end
      end else begin
        lvl_prev = 1'b0;
      end
      if (rose && ph == PH_ARMED) begin
        relay = 1'b1;
        ph    = PH_RUN;
        left  = run_len;
        count = count + 32'd1;
        quot  = count / {15'd0, mtpos_pkg::SLOT_DIVISOR};
        if (quot != {24'd0, slot}) begin
          slot         = quot[7:0];
          r.store_slot = 1'b1;
        end
        r.store_total = 1'b1;
      end
    end
    r.relay_on    = relay;
    r.event_total = count;
    r.slot_now    = slot;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    mtpos_pkg::result_t r;
    if (rst) begin
      run_len  = mtpos_pkg::RESET_TICKS;
      hold_len = mtpos_pkg::RESET_TICKS;
      ph       = PH_ARMED;
      left     = '0;
      lvl_prev = 1'b1;
      relay    = 1'b0;
      count    = mtpos_pkg::RESET_START_COUNT;
      slot     = mtpos_pkg::RESET_START_SLOT;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mtpos_pkg::REG_RUN_TICKS:   run_len  = cfg_data[15:0];
          mtpos_pkg::REG_HOLD_TICKS:  hold_len = cfg_data[15:0];
          mtpos_pkg::REG_START_COUNT: count    = cfg_data;
          mtpos_pkg::REG_START_SLOT:  slot     = cfg_data[7:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (due_results.size() == 0) begin
          $error("result transaction with no tick waiting for it");
          errs++;
        end else begin
          r = due_results.pop_front();
          check_field("relay_on", 32'(r.relay_on), 32'(result.relay_on));
          check_field("event_total", r.event_total, result.event_total);
          check_field("slot_now", 32'(r.slot_now), 32'(result.slot_now));
          check_field("store_slot", 32'(r.store_slot), 32'(result.store_slot));
          check_field("store_total", 32'(r.store_total), 32'(result.store_total));
        end
      end
      if (item_valid && !item_stall) begin
        advance_pump(item, r);
        due_results.push_back(r);
      end
    end
    fail_count <= errs;
    pending    <= due_results.size();
  end

endmodule

// ===== verif/motion_triggered_pump_one_shot_test.sv =====
// ----------------------------------------------------------------------------
// motion_triggered_pump_one_shot_test: testbench of the pump one-shot
// A directed run over edge detection, test mode, zero-length timers, count
// wrap and large slot quotients, then phases of random ticks under several
// timer and start settings, with bursty ticks and a stalling result side.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module motion_triggered_pump_one_shot_test;

  logic               clk = 1'b0;
  logic               rst;
  logic               item_valid;
  logic               item_stall;
  mtpos_pkg::item_t   item;
  logic               result_valid;
  logic               result_stall = 1'b0;
  mtpos_pkg::result_t result;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_data;
  int                 fail_count;
  int                 pending;

  // sender state: burst length left, whether gaps are used, valid driven high
  int   burst_left = 0;
  bit   gappy      = 1'b1;
  bit   valid_up   = 1'b0;
  int   ticks_sent = 0;

  // receiver stall pattern state
  int   stall_cyc  = 0;
  int   stall_mode = 0;

  motion_triggered_pump_one_shot dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  mtpos_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always #1 clk = ~clk;

  // receiver stalls: the pattern is redrawn periodically among none,
  // light random, heavy random and a fixed rhythm
  always @(posedge clk) begin
    logic s;
    if (stall_cyc % 80 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       s = 1'b0;
      1:       s = ($urandom_range(0, 3) == 0);
      2:       s = ($urandom_range(0, 9) < 7);
      default: s = (stall_cyc % 4 == 1) || (stall_cyc % 4 == 2);
    endcase
    result_stall <= s;
    stall_cyc++;
  end

  // one tick transaction; gaps fall between bursts of random length
  task automatic send_tick(input logic lvl, input logic tst);
    mtpos_pkg::item_t t;
    int               gap;
    t.sensor_level = lvl;
    t.test_mode    = tst;
    item_valid <= 1'b1;
    item       <= t;
    valid_up    = 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    ticks_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gappy ? $urandom_range(1, 5) : 0;
      if (gap != 0) begin
        item_valid <= 1'b0;
        valid_up    = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // stop sending and wait until every predicted result has been taken;
  // the first edge lets the checker's count catch up with the last tick
  task automatic wait_idle();
    if (valid_up) begin
      item_valid <= 1'b0;
      valid_up    = 1'b0;
    end
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // all four registers, written only while the block is idle
  task automatic write_regs(input logic [15:0] run_v, input logic [15:0] hold_v,
                            input logic [31:0] count_v, input logic [7:0] slot_v);
    logic [1:0]  idx  [4];
    logic [31:0] vals [4];
    idx[0] = mtpos_pkg::REG_RUN_TICKS;   vals[0] = {16'd0, run_v};
    idx[1] = mtpos_pkg::REG_HOLD_TICKS;  vals[1] = {16'd0, hold_v};
    idx[2] = mtpos_pkg::REG_START_COUNT; vals[2] = count_v;
    idx[3] = mtpos_pkg::REG_START_SLOT;  vals[3] = {24'd0, slot_v};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // timer lengths: mostly short so that runs and hold-offs expire often
  function automatic logic [15:0] pick_ticks();
    case ($urandom_range(0, 11))
      0:       return 16'd0;
      1:       return 16'hffff;
      2:       return 16'd1;
      3, 4:    return 16'($urandom_range(7, 40));
      default: return 16'($urandom_range(1, 6));
    endcase
  endfunction

  // start counts near wrap, near slot boundaries and past a quotient of 255
  function automatic logic [31:0] pick_count();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return 32'd0;
      2:       return 32'hffffffff - 32'($urandom_range(0, 5));
      3:       return 32'hffff * 32'($urandom_range(1, 300)) - 32'($urandom_range(0, 4));
      4:       return 32'hffff * 32'($urandom_range(255, 65537)) - 32'($urandom_range(0, 4));
      default: return 32'($urandom_range(0, 200));
    endcase
  endfunction

  initial begin
    logic [31:0] cnt;
    logic [7:0]  slt;
    logic        lvl;
    logic        tst;
    int          hold_cnt;
    int          phase_len;
    int          pause_at;
    bit          long_levels;

    // every input known from time zero
    rst          = 1'b1;
    item_valid   = 1'b0;
    item         = '0;
    cfg_valid    = 1'b0;
    cfg_index    = mtpos_pkg::REG_RUN_TICKS;
    cfg_data     = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: first high level is no edge, then a trigger, an edge
    // ignored during the run, test mode following the sensor mid-run
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    wait_idle();

    // zero-length timers act as one tick; count at the top of its range so
    // it wraps, with a quotient far past 255 and the slot at its maximum
    write_regs(16'd0, 16'd0, 32'hfffffffe, 8'hff);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    // timers keep running in test mode while the relay follows the sensor
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    wait_idle();

    // random phases, each with fresh settings and a forced pause
    ticks_sent = 0;
    lvl        = 1'b0;
    hold_cnt   = 0;
    while (ticks_sent < 750) begin
      cnt = pick_count();
      // slot either random or consistent with the count
      if ($urandom_range(0, 1) == 0) slt = 8'($urandom_range(0, 255));
      else slt = 8'(cnt / 32'hffff);
      write_regs(pick_ticks(), pick_ticks(), cnt, slt);
      gappy       = ($urandom_range(0, 3) != 0);
      long_levels = ($urandom_range(0, 2) == 0);
      phase_len   = $urandom_range(40, 110);
      pause_at    = $urandom_range(5, phase_len - 5);
      for (int i = 0; i < phase_len; i++) begin
        if (i == pause_at) wait_idle();
        if (hold_cnt == 0) begin
          lvl      = ~lvl;
          hold_cnt = long_levels ? $urandom_range(0, 12) : $urandom_range(0, 3);
        end else begin
          hold_cnt--;
        end
        tst = ($urandom_range(0, 99) < 12);
        send_tick(lvl, tst);
      end
      wait_idle();
    end

    // let the last results settle before the verdict
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("motion_triggered_pump_one_shot_test OK");
    end else begin
      $display("motion_triggered_pump_one_shot_test NOT OK");
    end
    $finish;
  end

  // watchdog far beyond the slowest legitimate run
  initial begin
    #400000;
    $display("motion_triggered_pump_one_shot_test NOT OK");
    $finish;
  end

endmodule
